// ===== hdl/slc_pkg.sv =====
package slc_pkg;

  localparam int ADDR_W   = 32;
  localparam int SETS_LOG = 7;
  localparam int SETS     = 1 << SETS_LOG;
  localparam int WAYS     = 4;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int BSL_W     = 4;
  localparam int BSL_MIN   = 2;
  localparam int BSL_MAX   = 12;
  localparam int BSL_RESET = 6;

  localparam int TAG_W     = ADDR_W - BSL_MIN - SETS_LOG;
  localparam int SH_W      = $clog2(ADDR_W);
  localparam int CNT_W     = 32;
  localparam int OUT_WAY_W = 2;

  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_IDX_W = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_BSL = CFG_IDX_W'(0);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [WAYS-1:0][WAY_W-1:0] lru;
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    row_t             new_row;
  } upd_t;

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int i = 0; i < WAYS; i++) begin
      r.lru[i] = WAY_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BSL_W-1:0] clamp_bsl(input logic [BSL_W-1:0] b);
    logic [BSL_W-1:0] r;
    r = b;
    if (b < BSL_W'(BSL_MIN)) begin
      r = BSL_W'(BSL_MIN);
    end else if (b > BSL_W'(BSL_MAX)) begin
      r = BSL_W'(BSL_MAX);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hdl/slc_if.sv =====
interface slc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [slc_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface slc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [slc_pkg::OUT_WAY_W-1:0]   way_used;
  logic [slc_pkg::CNT_W-1:0]       read_requests;
  logic [slc_pkg::CNT_W-1:0]       read_hits;
  logic [slc_pkg::CNT_W-1:0]       write_requests;
  logic [slc_pkg::CNT_W-1:0]       write_hits;

  modport source (output valid, output hit, output way_used, output read_requests,
                  output read_hits, output write_requests, output write_hits, input ready);
  modport sink   (input valid, input hit, input way_used, input read_requests,
                  input read_hits, input write_requests, input write_hits, output ready);
endinterface

// ===== hdl/set_associative_lru_cache_model_core.sv =====
// Port group | Direction | Carries
// in_if      | sink      | beat: cmd, address
// out_if     | source    | beat: hit, way_used, four saturating counters
// APB        | slave     | block_size_log at byte address 0
//
// Each access reads the set row from the set RAM in S_IDLE, then in S_LOOK
// updates tags, valid bits and LRU order and writes the row back.
// The update cycle holds while the previous result is unread; in_if.ready stays low.
// Reset is synchronous; per-set valid flags are cleared at once, no sweep.
// Set rows never written read as all-invalid with ways in ascending order.
module set_associative_lru_cache_model_core (
  input  logic                        clk,
  input  logic                        rst_n,
  slc_in_if.sink                      in_if,
  slc_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slc_pkg::CFG_AW-1:0]  paddr,
  input  logic [slc_pkg::CFG_DW-1:0]  pwdata,
  output logic [slc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t                            state_r;
  logic                              cmd_r;
  logic [slc_pkg::SETS_LOG-1:0]      set_r;
  logic [slc_pkg::TAG_W-1:0]         tag_r;
  logic [slc_pkg::SETS-1:0]          row_vld_r;
  logic                              out_valid_r;
  logic                              hit_r;
  logic [slc_pkg::OUT_WAY_W-1:0]     way_r;
  logic [slc_pkg::CNT_W-1:0]         rd_cnt_r;
  logic [slc_pkg::CNT_W-1:0]         rd_hit_r;
  logic [slc_pkg::CNT_W-1:0]         wr_cnt_r;
  logic [slc_pkg::CNT_W-1:0]         wr_hit_r;

  logic [slc_pkg::BSL_W-1:0]         bsl;
  logic [slc_pkg::BSL_W-1:0]         bsl_c;
  logic [slc_pkg::SH_W-1:0]          sh;
  logic [slc_pkg::SETS_LOG-1:0]      in_set;
  logic [slc_pkg::TAG_W-1:0]         in_tag;
  logic [slc_pkg::SETS_LOG-1:0]      raddr;
  logic                              accept;
  logic                              ram_we;
  slc_pkg::row_t                     rd_row;
  slc_pkg::upd_t                     upd;

  slc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bsl     (bsl)
  );

  assign bsl_c  = slc_pkg::clamp_bsl(bsl);
  assign sh     = slc_pkg::SH_W'(bsl_c) + slc_pkg::SH_W'(slc_pkg::SETS_LOG);
  assign in_set = slc_pkg::SETS_LOG'(in_if.address >> bsl_c);
  assign in_tag = slc_pkg::TAG_W'(in_if.address >> sh);

  assign accept = in_if.valid && in_if.ready;
  assign raddr  = (state_r == S_IDLE) ? in_set : set_r;
  assign ram_we = (state_r == S_LOOK) && (!out_valid_r || out_if.ready);

  slc_ram #(
    .WIDTH (slc_pkg::ROW_W),
    .DEPTH (slc_pkg::SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (upd.new_row),
    .raddr (raddr),
    .rdata (rd_row)
  );

  slc_update u_update (
    .row_in (rd_row),
    .row_ok (row_vld_r[set_r]),
    .tag    (tag_r),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      rd_cnt_r    <= '0;
      rd_hit_r    <= '0;
      wr_cnt_r    <= '0;
      wr_hit_r    <= '0;
    end else begin
      if (ram_we) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_if.cmd;
            set_r   <= in_set;
            tag_r   <= in_tag;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (ram_we) begin
            hit_r            <= upd.hit;
            way_r            <= slc_pkg::OUT_WAY_W'(upd.way);
            row_vld_r[set_r] <= 1'b1;
            if (cmd_r == slc_pkg::CMD_WRITE) begin
              wr_cnt_r <= slc_pkg::sat_inc(wr_cnt_r);
              if (upd.hit) begin
                wr_hit_r <= slc_pkg::sat_inc(wr_hit_r);
              end
            end else begin
              rd_cnt_r <= slc_pkg::sat_inc(rd_cnt_r);
              if (upd.hit) begin
                rd_hit_r <= slc_pkg::sat_inc(rd_hit_r);
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.hit            = hit_r;
  assign out_if.way_used       = way_r;
  assign out_if.read_requests  = rd_cnt_r;
  assign out_if.read_hits      = rd_hit_r;
  assign out_if.write_requests = wr_cnt_r;
  assign out_if.write_hits     = wr_hit_r;

`ifndef SYNTH
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOOK))
    else $error("accepted beat did not start a set lookup");

  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("row writeback without a published result");

  a_wb_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> row_vld_r[$past(set_r)])
    else $error("written set row not marked valid");

  a_used_newest: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((upd.new_row.lru[slc_pkg::WAYS - 1] == upd.way) && upd.new_row.vld[upd.way]))
    else $error("used way is not newest and valid after update");
`endif

endmodule

// ===== hdl/slc_ram.sv =====
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/slc_cfg.sv =====
module slc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slc_pkg::CFG_AW-1:0]  paddr,
  input  logic [slc_pkg::CFG_DW-1:0]  pwdata,
  output logic [slc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [slc_pkg::BSL_W-1:0]   bsl
);

  logic [slc_pkg::BSL_W-1:0]     bsl_r;
  logic [slc_pkg::CFG_IDX_W-1:0] idx;
  logic                          wr;

  assign idx = paddr[slc_pkg::CFG_AW-1:2];
  assign wr  = psel && penable && pwrite && (idx == slc_pkg::REG_BSL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r <= slc_pkg::BSL_W'(slc_pkg::BSL_RESET);
    end else if (wr) begin
      bsl_r <= pwdata[slc_pkg::BSL_W-1:0];
    end
  end

  assign prdata = (idx == slc_pkg::REG_BSL) ? slc_pkg::CFG_DW'(bsl_r) : '0;
  assign pready = 1'b1;
  assign bsl    = bsl_r;

endmodule

// ===== hdl/slc_update.sv =====
module slc_update (
  input  slc_pkg::row_t              row_in,
  input  logic                       row_ok,
  input  logic [slc_pkg::TAG_W-1:0]  tag,
  output slc_pkg::upd_t              upd
);

  slc_pkg::row_t                 row;
  slc_pkg::row_t                 new_row;
  logic                          hit;
  logic                          seen;
  logic [slc_pkg::WAY_W-1:0]     way;

  always_comb begin
    row = row_ok ? row_in : slc_pkg::reset_row();
    hit = 1'b0;
    way = '0;
    for (int w = slc_pkg::WAYS - 1; w >= 0; w--) begin
      if (row.vld[w] && (row.tag[w] == tag)) begin
        hit = 1'b1;
        way = slc_pkg::WAY_W'(w);
      end
    end
    if (!hit) begin
      way = row.lru[0];
      if ({1'b0, way} >= (slc_pkg::WAY_W + 1)'(slc_pkg::WAYS)) begin
        way = '0;
      end
    end

    new_row = row;
    if (!hit) begin
      new_row.tag[way] = tag;
      new_row.vld[way] = 1'b1;
    end

    // move the used way to the newest end, close the gap behind it
    seen = 1'b0;
    for (int i = 0; i < slc_pkg::WAYS - 1; i++) begin
      seen = seen | (row.lru[i] == way);
      if (seen) begin
        new_row.lru[i] = row.lru[i + 1];
      end
    end
    seen = seen | (row.lru[slc_pkg::WAYS - 1] == way);
    if (seen) begin
      new_row.lru[slc_pkg::WAYS - 1] = way;
    end

    upd.hit     = hit;
    upd.way     = way;
    upd.new_row = new_row;
  end

endmodule

// ===== tb/slc_access_checker.sv =====
module slc_access_checker
  import slc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  slc_in_if                 in_ch,
  slc_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [CNT_W-1:0]     rd_req;
    logic [CNT_W-1:0]     rd_hit;
    logic [CNT_W-1:0]     wr_req;
    logic [CNT_W-1:0]     wr_hit;
  } access_result_t;

  logic [ADDR_W-1:0] tag_mem   [SETS][WAYS];
  logic              valid_mem [SETS][WAYS];
  logic [WAY_W-1:0]  age_order [SETS][WAYS];
  logic [CNT_W-1:0]  rd_req_cnt, rd_hit_cnt, wr_req_cnt, wr_hit_cnt;
  logic [BSL_W-1:0]  block_size_log;

  access_result_t awaited_results[$];
  access_result_t want;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  task automatic clear_cache();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w]   = '0;
        valid_mem[s][w] = 1'b0;
        age_order[s][w] = WAY_W'(w);
      end
    end
    rd_req_cnt     = '0;
    rd_hit_cnt     = '0;
    wr_req_cnt     = '0;
    wr_hit_cnt     = '0;
    block_size_log = BSL_W'(BSL_RESET);
  endtask

  function automatic access_result_t cache_lookup(input logic cmd, input logic [ADDR_W-1:0] addr);
    access_result_t r;
    int unsigned    b;
    int unsigned    set_idx;
    logic [ADDR_W-1:0] tag;
    int unsigned    way;
    int unsigned    pos;
    logic           hit;
    b = block_size_log;
    if (b < BSL_MIN) b = BSL_MIN;
    if (b > BSL_MAX) b = BSL_MAX;
    set_idx = (addr >> b) & (SETS - 1);
    tag     = addr >> (b + SETS_LOG);
    hit     = 1'b0;
    way     = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_mem[set_idx][w] && tag_mem[set_idx][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (!hit) begin
      way = age_order[set_idx][0];
      tag_mem[set_idx][way]   = tag;
      valid_mem[set_idx][way] = 1'b1;
    end
    pos = WAYS;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (age_order[set_idx][i] == WAY_W'(way)) pos = i;
    end
    if (pos < WAYS) begin
      for (int i = pos; i + 1 < WAYS; i++) begin
        age_order[set_idx][i] = age_order[set_idx][i + 1];
      end
      age_order[set_idx][WAYS - 1] = WAY_W'(way);
    end
    if (cmd == CMD_WRITE) begin
      wr_req_cnt = bump(wr_req_cnt);
      if (hit) wr_hit_cnt = bump(wr_hit_cnt);
    end else begin
      rd_req_cnt = bump(rd_req_cnt);
      if (hit) rd_hit_cnt = bump(rd_hit_cnt);
    end
    r.hit    = hit;
    r.way    = OUT_WAY_W'(way);
    r.rd_req = rd_req_cnt;
    r.rd_hit = rd_hit_cnt;
    r.wr_req = wr_req_cnt;
    r.wr_hit = wr_hit_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_cache();
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result beat", '0, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(out_ch.hit));
          if (out_ch.way_used !== want.way)
            report_mismatch("way_used", 32'(want.way), 32'(out_ch.way_used));
          if (out_ch.read_requests !== want.rd_req)
            report_mismatch("read_requests", want.rd_req, out_ch.read_requests);
          if (out_ch.read_hits !== want.rd_hit)
            report_mismatch("read_hits", want.rd_hit, out_ch.read_hits);
          if (out_ch.write_requests !== want.wr_req)
            report_mismatch("write_requests", want.wr_req, out_ch.write_requests);
          if (out_ch.write_hits !== want.wr_hit)
            report_mismatch("write_hits", want.wr_hit, out_ch.write_hits);
        end
      end
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_BSL) begin
        block_size_log = pwdata[BSL_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(cache_lookup(in_ch.cmd, in_ch.address));
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== tb/tb_set_associative_lru_cache_model_core.sv =====
module tb_set_associative_lru_cache_model_core;
  import slc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_BEATS  = 110;
  localparam int TAIL_CYCLES  = 20;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                errors;
  int                outstanding;
  int                quiet_cycles;
  logic              calm;

  slc_in_if  in_ch();
  slc_out_if out_ch();

  set_associative_lru_cache_model_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slc_access_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    calm           = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_READ;
    in_ch.address  = '0;
    out_ch.ready   = 1'b0;
    quiet_cycles   = 0;
  end

  // result side back-pressure: bursts low, stretches high
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_block_size(input logic [BSL_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BSL, 2'b00};
    pwdata  <= {(CFG_DW - BSL_W)'($urandom()), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly a small pool of tags over a few neighbouring sets, so hits and evictions occur
  task automatic send_mixed(input int unsigned b, input logic [ADDR_W-1:0] tag_base,
                            input logic [SETS_LOG-1:0] set_base);
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   tg;
    logic [SETS_LOG-1:0] st;
    if ($urandom_range(0, 9) < 2) begin
      addr = $urandom();
    end else begin
      tg   = tag_base + $urandom_range(0, 5);
      st   = set_base + SETS_LOG'($urandom_range(0, 3));
      addr = (tg << (b + SETS_LOG)) | (ADDR_W'(st) << b) |
             (ADDR_W'($urandom()) & ((ADDR_W'(1) << b) - 1));
    end
    send_beat(1'($urandom_range(0, 1)), addr);
  endtask

  initial begin
    logic [BSL_W-1:0]    phase_bsl [10];
    int unsigned         b;
    logic [ADDR_W-1:0]   tag_base;
    logic [SETS_LOG-1:0] set_base;
    phase_bsl = '{4'd2, 4'd12, 4'd0, 4'd15, 4'd9, 4'd13, 4'd1, 4'd6, 4'd4, 4'd3};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset block size: offset 6 bits, set 12:6, tag 31:13
    send_beat(CMD_READ,  32'h0000_0000);
    send_beat(CMD_WRITE, 32'h0000_0000);
    send_beat(CMD_READ,  32'hFFFF_FFFF);
    send_beat(CMD_WRITE, 32'hFFFF_FFFF);
    send_beat(CMD_READ,  32'h0000_203F);
    send_beat(CMD_WRITE, 32'h0000_4000);
    send_beat(CMD_READ,  32'h0000_6000);
    send_beat(CMD_WRITE, 32'h0000_8000);
    send_beat(CMD_READ,  32'h0000_2000);
    send_beat(CMD_READ,  32'h0000_0000);
    send_beat(CMD_WRITE, 32'h0000_4000);
    send_beat(CMD_READ,  32'h0000_003F);
    send_beat(CMD_WRITE, 32'hAAAA_AAAA);
    send_beat(CMD_READ,  32'h5555_5555);
    send_beat(CMD_READ,  32'hAAAA_AAAA);
    send_beat(CMD_WRITE, 32'hFFFF_FFC0);
    send_beat(CMD_READ,  32'h8000_0000);

    foreach (phase_bsl[p]) begin
      drain();
      write_block_size(phase_bsl[p]);
      if (p == 9) calm = 1'b1;
      b = phase_bsl[p];
      if (b < BSL_MIN) b = BSL_MIN;
      if (b > BSL_MAX) b = BSL_MAX;
      tag_base = $urandom();
      set_base = SETS_LOG'($urandom());
      repeat (PHASE_BEATS) send_mixed(b, tag_base, set_base);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/slc_pkg.sv
hdl/slc_if.sv
hdl/slc_ram.sv
hdl/slc_cfg.sv
hdl/slc_update.sv
hdl/set_associative_lru_cache_model_core.sv
tb/slc_access_checker.sv
tb/tb_set_associative_lru_cache_model_core.sv
